[sv/adf_pkg.sv]
// shared constants, types and tables of the adc decimator / fir smoother
// no dependencies: every other file of the block imports this package
`default_nettype none

package adf_pkg;

   localparam int CHANNELS     = 3;
   localparam int TAPS         = 11;
   localparam int SAMPLE_BITS  = 12;
   localparam int COUNT_BITS   = 10;
   localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
   localparam int CH_BITS      = 2;
   localparam int COEF_BITS    = 16;
   localparam int PROD_BITS    = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS     = PROD_BITS + 1;
   localparam int TAP_BITS     = $clog2(TAPS);
   localparam int MEM_DEPTH    = CHANNELS * TAPS;
   localparam int MEM_AW       = $clog2(MEM_DEPTH);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS    = SUM_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [COUNT_BITS-1:0]  SPC_RESET  = COUNT_BITS'(700);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic [CH_BITS-1:0]     ch_type;

   // one finished block, handed from the front to the back
   typedef struct packed {
      ch_type    ch;
      ch_type    next_ch;
      sum_type   sum;
      count_type count;
   } job_type;

   // q0.16 smoothing weights, symmetric around the center tap
   function automatic logic [COEF_BITS-1:0] coef_lookup(input logic [TAP_BITS-1:0] tap);
      logic [COEF_BITS-1:0] c;
      case (tap)
         4'd0:    c = 16'd2610;
         4'd1:    c = 16'd4350;
         4'd2:    c = 16'd6090;
         4'd3:    c = 16'd7250;
         4'd4:    c = 16'd8120;
         4'd5:    c = 16'd8699;
         4'd6:    c = 16'd8120;
         4'd7:    c = 16'd7250;
         4'd8:    c = 16'd6090;
         4'd9:    c = 16'd4350;
         4'd10:   c = 16'd2610;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic ch_type next_ch(input ch_type ch);
      ch_type n;
      if (ch >= CH_BITS'(CHANNELS - 1)) begin
         n = '0;
      end else begin
         n = ch + 1'b1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

[sv/adf_front.sv]
// front end: accumulates samples of the selected channel and closes blocks
// depends on adf_pkg; feeds closed blocks into adf_queue
`default_nettype none

module adf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire adf_pkg::count_type  spc,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire adf_pkg::sample_type req_adc_sample,
   input  wire logic                queue_full,
   output logic                     push_valid,
   output adf_pkg::job_type         push_job
);
   import adf_pkg::*;

   sum_type   sum_ff,   sum_in;
   count_type count_ff, count_in;
   ch_type    ch_ff,    ch_in;

   logic      accept;
   logic      block_done;
   sum_type   sum_next;
   count_type count_next;
   ch_type    ch_cur;

   assign req_stall  = queue_full;
   assign accept     = req_valid & ~queue_full;
   assign sum_next   = sum_ff + SUM_BITS'(req_adc_sample);
   assign count_next = count_ff + 1'b1;
   // a register value of zero closes a block on every item
   assign block_done = !(count_next < spc);
   assign ch_cur     = (ch_ff >= CH_BITS'(CHANNELS)) ? '0 : ch_ff;

   assign push_valid = accept & block_done;
   assign push_job   = '{ch: ch_cur, next_ch: next_ch(ch_cur), sum: sum_next,
                         count: count_next};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ch_in    = ch_ff;
      if (accept) begin
         if (block_done) begin
            sum_in   = '0;
            count_in = '0;
            ch_in    = next_ch(ch_cur);
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ch_ff    <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ch_ff    <= ch_in;
      end
   end

endmodule

`default_nettype wire

[sv/adf_queue.sv]
// short job queue between front and back, so each side stalls on its own
// depends on adf_pkg for the job type and depth
`default_nettype none

module adf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire adf_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output adf_pkg::job_type      pop_job,
   output logic                  empty
);
   import adf_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      fill_ff,   fill_in;

   assign full    = (fill_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[sv/adf_div.sv]
// restoring divider, one quotient bit per cycle: block sum over sample count
// depends on adf_pkg for widths; used by adf_back
`default_nettype none

module adf_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire adf_pkg::sum_type   dividend,
   input  wire adf_pkg::count_type divisor,
   output logic                    done,
   output adf_pkg::sum_type        quotient
);
   import adf_pkg::*;

   logic [COUNT_BITS:0]     rem_ff,  rem_in;
   sum_type                 quo_ff,  quo_in;
   count_type               dvs_ff,  dvs_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff,  cnt_in;
   logic                    run_ff,  run_in;
   logic                    done_ff, done_in;

   logic [COUNT_BITS:0]     rem_sh;
   logic                    fits;

   // dividend bits shift out of quo_ff as quotient bits shift in
   assign rem_sh   = {rem_ff[COUNT_BITS-1:0], quo_ff[SUM_BITS-1]};
   assign fits     = (rem_sh >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

endmodule

`default_nettype wire

[sv/adf_back.sv]
// back end: mean by division, per-channel delay lines in a memory, fir mac
// and the result register; depends on adf_pkg and adf_div
`default_nettype none

module adf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             queue_empty,
   input  wire adf_pkg::job_type pop_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output adf_pkg::ch_type       rsp_channel,
   output adf_pkg::sample_type   rsp_filtered_value,
   output adf_pkg::ch_type       rsp_next_channel
);
   import adf_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_MAC  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]            state_ff,    state_in;
   job_type               job_ff,      job_in;
   logic [MEM_AW-1:0]     base_ff,     base_in;
   sample_type            mean_ff,     mean_in;
   logic [TAP_BITS-1:0]   head_cur_ff, head_cur_in;
   logic [TAP_BITS-1:0]   iss_ff,      iss_in;
   logic                  iss_run_ff,  iss_run_in;
   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic [TAP_BITS-1:0]   s1_tap_ff;
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [PROD_BITS-1:0]  prod_ff,     prod_in;
   logic [ACC_BITS-1:0]   acc_ff,      acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ch_type                rsp_ch_ff;
   ch_type                rsp_next_ff;
   sample_type            rsp_value_ff;

   logic [TAP_BITS-1:0]   head_ff [CHANNELS];
   sample_type            tap_mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]  tap_vld_ff;
   sample_type            tap_rd_ff;
   logic                  tap_rd_vld_ff;

   logic                  div_done;
   sum_type               div_quo;
   logic [TAP_BITS-1:0]   head_old;
   logic [TAP_BITS-1:0]   head_new;
   sample_type            mean_new;
   logic                  wr_en;
   logic [MEM_AW-1:0]     wr_addr;
   logic [TAP_BITS:0]     idx_sum;
   logic [TAP_BITS:0]     idx_mod;
   logic [MEM_AW-1:0]     rd_addr;
   logic                  issue;
   sample_type            tap_val;
   logic                  out_free;
   logic                  load;
   logic [ACC_BITS-COEF_BITS-1:0] acc_int;

   adf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (pop),
      .dividend (pop_job.sum),
      .divisor  (pop_job.count),
      .done     (div_done),
      .quotient (div_quo)
   );

   // newest tap goes one slot below the old head, circularly
   assign head_old = head_ff[job_ff.ch];
   assign head_new = (head_old == '0) ? TAP_BITS'(TAPS - 1) : head_old - 1'b1;
   assign mean_new = (job_ff.count == '0) ? '0 : div_quo[SAMPLE_BITS-1:0];
   assign wr_addr  = base_ff + MEM_AW'(head_new);

   // tap i sits at (head + i) mod taps inside the channel's row
   assign idx_sum  = {1'b0, head_cur_ff} + {1'b0, iss_ff};
   assign idx_mod  = (idx_sum >= (TAP_BITS + 1)'(TAPS)) ? idx_sum - (TAP_BITS + 1)'(TAPS)
                                                        : idx_sum;
   assign rd_addr  = base_ff + MEM_AW'(idx_mod[TAP_BITS-1:0]);
   assign issue    = (state_ff == S_MAC) && iss_run_ff;

   // tap 0 is the fresh mean, never-written taps read as zero
   assign tap_val  = (s1_tap_ff == '0) ? mean_ff : (tap_rd_vld_ff ? tap_rd_ff : '0);
   assign prod_in  = PROD_BITS'(coef_lookup(s1_tap_ff) * tap_val);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign acc_int  = acc_ff[ACC_BITS-1:COEF_BITS];

   always_comb begin
      state_in    = state_ff;
      job_in      = job_ff;
      base_in     = base_ff;
      mean_in     = mean_ff;
      head_cur_in = head_cur_ff;
      iss_in      = iss_ff;
      iss_run_in  = iss_run_ff;
      acc_in      = acc_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      load        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = pop_job;
               base_in  = MEM_AW'(MEM_AW'(pop_job.ch) * MEM_AW'(TAPS));
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               wr_en       = 1'b1;
               mean_in     = mean_new;
               head_cur_in = head_new;
               iss_in      = '0;
               iss_run_in  = 1'b1;
               acc_in      = '0;
               state_in    = S_MAC;
            end
         end
         S_MAC: begin
            if (iss_run_ff) begin
               iss_in = iss_ff + 1'b1;
               if (iss_ff == TAP_BITS'(TAPS - 1)) begin
                  iss_run_in = 1'b0;
               end
            end
            if (s2_valid_ff) begin
               acc_in = acc_ff + ACC_BITS'(prod_ff);
               if (s2_last_ff) begin
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_run_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_vld_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            head_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         iss_run_ff   <= iss_run_in;
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            tap_vld_ff[wr_addr] <= 1'b1;
            head_ff[job_ff.ch]  <= head_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      base_ff     <= base_in;
      mean_ff     <= mean_in;
      head_cur_ff <= head_cur_in;
      iss_ff      <= iss_in;
      acc_ff      <= acc_in;
      s1_tap_ff   <= iss_ff;
      s1_last_ff  <= (iss_ff == TAP_BITS'(TAPS - 1));
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= prod_in;
      if (load) begin
         rsp_ch_ff    <= job_ff.ch;
         rsp_next_ff  <= job_ff.next_ch;
         rsp_value_ff <= (acc_int > (ACC_BITS - COEF_BITS)'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                        : acc_int[SAMPLE_BITS-1:0];
      end
   end

   // delay line memory: at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tap_mem_ff[wr_addr] <= mean_new;
      end
      tap_rd_ff     <= tap_mem_ff[rd_addr];
      tap_rd_vld_ff <= tap_vld_ff[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_ch_ff;
   assign rsp_next_channel   = rsp_next_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule

`default_nettype wire

[sv/adc_decimate_fir_scanner_top.sv]
// Three-channel boxcar decimator with 11-tap FIR smoothing. Every item is one
// 12-bit sample of the channel after the one whose block closed last (channel 0
// after reset). After samples_per_channel items (0 acts as 1) the floored mean
// of the block goes into that channel's delay line and one filtered result
// comes out; other items give no result. Items that do not close a block are
// taken one per cycle while the queue has room. A closing item hands its block
// to a two-entry queue; the back end takes one block at a time: it pops it,
// runs the bit-serial divider until its done flag, makes the one-multiplier
// FIR pass and loads the result register once that is free. While the queue
// is full the front stalls every item until a queue entry frees. The register
// port accepts a write in every cycle and should only be written while the
// block is idle.
// top level: register, front end, job queue and back end
// depends on adf_pkg, adf_front, adf_queue and adf_back
`default_nettype none

module adc_decimate_fir_scanner_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire adf_pkg::sample_type req_adc_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output adf_pkg::ch_type          rsp_channel,
   output adf_pkg::sample_type      rsp_filtered_value,
   output adf_pkg::ch_type          rsp_next_channel,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire adf_pkg::count_type  csr_samples_per_channel
);
   import adf_pkg::*;

   count_type spc_ff, spc_in;
   logic      queue_full;
   logic      queue_empty;
   logic      push_valid;
   job_type   push_job;
   logic      pop;
   job_type   pop_job;

   assign csr_ready = 1'b1;
   assign spc_in    = (csr_valid && csr_ready) ? csr_samples_per_channel : spc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff <= SPC_RESET;
      end else begin
         spc_ff <= spc_in;
      end
   end

   adf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .spc            (spc_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_job       (push_job)
   );

   adf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   adf_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .pop_job            (pop_job),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_channel        (rsp_channel),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_next_channel   (rsp_next_channel)
   );

endmodule

`default_nettype wire

[sv/adf_checker.sv]
// port-level checks of the decimator top level, attached by the bind below
// depends on adf_pkg and adc_decimate_fir_scanner_top
`default_nettype none

module adf_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire adf_pkg::ch_type     rsp_channel,
   input wire adf_pkg::sample_type rsp_filtered_value,
   input wire adf_pkg::ch_type     rsp_next_channel
);
   import adf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_channel)
         && $stable(rsp_filtered_value) && $stable(rsp_next_channel))
      else $error("result item changed while stalled");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel < CH_BITS'(CHANNELS))
      else $error("result names a channel that does not exist");

   a_round_robin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_channel == next_ch(rsp_channel))
      else $error("next channel is not the round-robin successor");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result item shown right after reset");

endmodule

bind adc_decimate_fir_scanner_top adf_checker u_adf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_channel        (rsp_channel),
   .rsp_filtered_value (rsp_filtered_value),
   .rsp_next_channel   (rsp_next_channel)
);

`default_nettype wire
